[rtl/segx_pkg.sv]
// shared widths and payload types for the segment intersection test
package segx_pkg;

    // coordinate width; every internal width below follows from it
    localparam int COORD_WIDTH = 16;

    // line coefficients a and b: difference of two coordinates
    localparam int COEF_WIDTH  = COORD_WIDTH + 1;
    // coordinate by coordinate product
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    // coefficient c: difference of two products
    localparam int CC_WIDTH    = PROD_WIDTH + 1;
    // a by b product
    localparam int AB_WIDTH    = 2 * COEF_WIDTH;
    // determinant, one spare bit so that its negation fits
    localparam int DET_WIDTH   = AB_WIDTH + 1;
    // b by c product
    localparam int BC_WIDTH    = COEF_WIDTH + CC_WIDTH;
    // crossing numerators and scaled bounds share one width
    localparam int NUM_WIDTH   = BC_WIDTH + 1;
    localparam int BND_WIDTH   = COORD_WIDTH + DET_WIDTH;
    localparam int CMP_WIDTH   = (NUM_WIDTH > BND_WIDTH) ? NUM_WIDTH : BND_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t seg1_start_x;
        coord_t seg1_start_y;
        coord_t seg1_end_x;
        coord_t seg1_end_y;
        coord_t seg2_start_x;
        coord_t seg2_start_y;
        coord_t seg2_end_x;
        coord_t seg2_end_y;
    } seg_pair_t;

    typedef struct packed {
        logic crosses;
        logic parallel;
    } seg_result_t;

    // bounding interval of one axis of one segment
    typedef struct packed {
        coord_t lo;
        coord_t hi;
    } span_t;

endpackage

[rtl/segment_intersection_test.sv]
// top level: pipelined exact test of whether two line segments cross
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  s_      | in        | s_valid / s_ready  | s_data  (two segments, 8 coords)
//  m_      | out       | m_valid / m_ready  | m_data  (crosses, parallel)
//
//  six register stages; a segment pair enters every cycle when the output
//  side keeps up, and its result leaves from the stage 6 result register
//  the multiply stages (coefficients, determinant, numerators, scaled
//  bounds) set the stage count: one product per path between registers
//  reset (aresetn low at a clock edge) empties the pipeline; no other state
//  each stage holds while the one after it is full and stalled, so a stall
//  on m_ready backs up stage by stage and bubbles ahead of it still close
module segment_intersection_test (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  segx_pkg::seg_pair_t     s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output segx_pkg::seg_result_t   m_data
);
    import segx_pkg::*;

    // ------------------------------------------------------------------
    // stage enables: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_valid_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !m_valid_reg || m_ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_ready = en1;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg      <= s_valid;
            if (en2) v2_reg      <= v1_reg;
            if (en3) v3_reg      <= v2_reg;
            if (en4) v4_reg      <= v3_reg;
            if (en5) v5_reg      <= v4_reg;
            if (en6) m_valid_reg <= v5_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: a and b coefficients, the four products of c, bounding boxes
    // ------------------------------------------------------------------
    logic signed [COEF_WIDTH-1:0] a1_next, b1_next, a2_next, b2_next;
    logic signed [COEF_WIDTH-1:0] a1_s1_reg, b1_s1_reg, a2_s1_reg, b2_s1_reg;
    logic signed [PROD_WIDTH-1:0] p1a_next, p1b_next, p2a_next, p2b_next;
    logic signed [PROD_WIDTH-1:0] p1a_reg, p1b_reg, p2a_reg, p2b_reg;
    span_t sx1_next, sy1_next, sx2_next, sy2_next;
    span_t sx1_s1_reg, sy1_s1_reg, sx2_s1_reg, sy2_s1_reg;

    always_comb begin
        // a = y0 - y1, b = x1 - x0
        a1_next = COEF_WIDTH'(s_data.seg1_start_y) - COEF_WIDTH'(s_data.seg1_end_y);
        b1_next = COEF_WIDTH'(s_data.seg1_end_x) - COEF_WIDTH'(s_data.seg1_start_x);
        a2_next = COEF_WIDTH'(s_data.seg2_start_y) - COEF_WIDTH'(s_data.seg2_end_y);
        b2_next = COEF_WIDTH'(s_data.seg2_end_x) - COEF_WIDTH'(s_data.seg2_start_x);

        // c = x0*y1 - x1*y0, products here and the difference next stage
        p1a_next = PROD_WIDTH'(s_data.seg1_start_x) * PROD_WIDTH'(s_data.seg1_end_y);
        p1b_next = PROD_WIDTH'(s_data.seg1_end_x) * PROD_WIDTH'(s_data.seg1_start_y);
        p2a_next = PROD_WIDTH'(s_data.seg2_start_x) * PROD_WIDTH'(s_data.seg2_end_y);
        p2b_next = PROD_WIDTH'(s_data.seg2_end_x) * PROD_WIDTH'(s_data.seg2_start_y);

        // bounding boxes, bounds included
        if (s_data.seg1_start_x < s_data.seg1_end_x) begin
            sx1_next = '{lo: s_data.seg1_start_x, hi: s_data.seg1_end_x};
        end else begin
            sx1_next = '{lo: s_data.seg1_end_x, hi: s_data.seg1_start_x};
        end
        if (s_data.seg1_start_y < s_data.seg1_end_y) begin
            sy1_next = '{lo: s_data.seg1_start_y, hi: s_data.seg1_end_y};
        end else begin
            sy1_next = '{lo: s_data.seg1_end_y, hi: s_data.seg1_start_y};
        end
        if (s_data.seg2_start_x < s_data.seg2_end_x) begin
            sx2_next = '{lo: s_data.seg2_start_x, hi: s_data.seg2_end_x};
        end else begin
            sx2_next = '{lo: s_data.seg2_end_x, hi: s_data.seg2_start_x};
        end
        if (s_data.seg2_start_y < s_data.seg2_end_y) begin
            sy2_next = '{lo: s_data.seg2_start_y, hi: s_data.seg2_end_y};
        end else begin
            sy2_next = '{lo: s_data.seg2_end_y, hi: s_data.seg2_start_y};
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            a1_s1_reg  <= a1_next;
            b1_s1_reg  <= b1_next;
            a2_s1_reg  <= a2_next;
            b2_s1_reg  <= b2_next;
            p1a_reg    <= p1a_next;
            p1b_reg    <= p1b_next;
            p2a_reg    <= p2a_next;
            p2b_reg    <= p2b_next;
            sx1_s1_reg <= sx1_next;
            sy1_s1_reg <= sy1_next;
            sx2_s1_reg <= sx2_next;
            sy2_s1_reg <= sy2_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: c coefficients, the two products of the determinant
    // ------------------------------------------------------------------
    logic signed [CC_WIDTH-1:0] c1_next, c2_next, c1_reg, c2_reg;
    logic signed [AB_WIDTH-1:0] da_next, db_next, da_reg, db_reg;
    logic signed [COEF_WIDTH-1:0] a1_s2_reg, b1_s2_reg, a2_s2_reg, b2_s2_reg;
    span_t sx1_s2_reg, sy1_s2_reg, sx2_s2_reg, sy2_s2_reg;

    always_comb begin
        c1_next = CC_WIDTH'(p1a_reg) - CC_WIDTH'(p1b_reg);
        c2_next = CC_WIDTH'(p2a_reg) - CC_WIDTH'(p2b_reg);
        da_next = AB_WIDTH'(a1_s1_reg) * AB_WIDTH'(b2_s1_reg);
        db_next = AB_WIDTH'(a2_s1_reg) * AB_WIDTH'(b1_s1_reg);
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            c1_reg     <= c1_next;
            c2_reg     <= c2_next;
            da_reg     <= da_next;
            db_reg     <= db_next;
            a1_s2_reg  <= a1_s1_reg;
            b1_s2_reg  <= b1_s1_reg;
            a2_s2_reg  <= a2_s1_reg;
            b2_s2_reg  <= b2_s1_reg;
            sx1_s2_reg <= sx1_s1_reg;
            sy1_s2_reg <= sy1_s1_reg;
            sx2_s2_reg <= sx2_s1_reg;
            sy2_s2_reg <= sy2_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: determinant, the four products of the crossing numerators
    // ------------------------------------------------------------------
    logic signed [DET_WIDTH-1:0] det_next, det_reg;
    logic signed [BC_WIDTH-1:0] m1_next, m2_next, m3_next, m4_next;
    logic signed [BC_WIDTH-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    span_t sx1_s3_reg, sy1_s3_reg, sx2_s3_reg, sy2_s3_reg;

    always_comb begin
        det_next = DET_WIDTH'(da_reg) - DET_WIDTH'(db_reg);
        // nx = b1*c2 - b2*c1, ny = a2*c1 - a1*c2
        m1_next  = BC_WIDTH'(b1_s2_reg) * BC_WIDTH'(c2_reg);
        m2_next  = BC_WIDTH'(b2_s2_reg) * BC_WIDTH'(c1_reg);
        m3_next  = BC_WIDTH'(a2_s2_reg) * BC_WIDTH'(c1_reg);
        m4_next  = BC_WIDTH'(a1_s2_reg) * BC_WIDTH'(c2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            det_reg    <= det_next;
            m1_reg     <= m1_next;
            m2_reg     <= m2_next;
            m3_reg     <= m3_next;
            m4_reg     <= m4_next;
            sx1_s3_reg <= sx1_s2_reg;
            sy1_s3_reg <= sy1_s2_reg;
            sx2_s3_reg <= sx2_s2_reg;
            sy2_s3_reg <= sy2_s2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: numerators, determinant sign and magnitude
    // ------------------------------------------------------------------
    logic signed [NUM_WIDTH-1:0] nx_next, ny_next, nx_reg, ny_reg;
    logic signed [DET_WIDTH-1:0] adet_next, adet_reg;
    logic neg_next, neg_reg, par_next, par_s4_reg;
    span_t sx1_s4_reg, sy1_s4_reg, sx2_s4_reg, sy2_s4_reg;

    always_comb begin
        nx_next   = NUM_WIDTH'(m1_reg) - NUM_WIDTH'(m2_reg);
        ny_next   = NUM_WIDTH'(m3_reg) - NUM_WIDTH'(m4_reg);
        neg_next  = det_reg[DET_WIDTH-1];
        par_next  = (det_reg == '0);
        adet_next = neg_next ? -det_reg : det_reg;
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            nx_reg     <= nx_next;
            ny_reg     <= ny_next;
            adet_reg   <= adet_next;
            neg_reg    <= neg_next;
            par_s4_reg <= par_next;
            sx1_s4_reg <= sx1_s3_reg;
            sy1_s4_reg <= sy1_s3_reg;
            sx2_s4_reg <= sx2_s3_reg;
            sy2_s4_reg <= sy2_s3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: numerators take the determinant's sign off, bounds scaled
    // by the determinant magnitude
    // ------------------------------------------------------------------
    logic signed [CMP_WIDTH-1:0] snx_next, sny_next, snx_reg, sny_reg;
    logic signed [CMP_WIDTH-1:0] x1lo_next, x1hi_next, y1lo_next, y1hi_next;
    logic signed [CMP_WIDTH-1:0] x2lo_next, x2hi_next, y2lo_next, y2hi_next;
    logic signed [CMP_WIDTH-1:0] x1lo_reg, x1hi_reg, y1lo_reg, y1hi_reg;
    logic signed [CMP_WIDTH-1:0] x2lo_reg, x2hi_reg, y2lo_reg, y2hi_reg;
    logic par_s5_reg;

    always_comb begin
        snx_next  = neg_reg ? -CMP_WIDTH'(nx_reg) : CMP_WIDTH'(nx_reg);
        sny_next  = neg_reg ? -CMP_WIDTH'(ny_reg) : CMP_WIDTH'(ny_reg);
        x1lo_next = CMP_WIDTH'(sx1_s4_reg.lo) * CMP_WIDTH'(adet_reg);
        x1hi_next = CMP_WIDTH'(sx1_s4_reg.hi) * CMP_WIDTH'(adet_reg);
        y1lo_next = CMP_WIDTH'(sy1_s4_reg.lo) * CMP_WIDTH'(adet_reg);
        y1hi_next = CMP_WIDTH'(sy1_s4_reg.hi) * CMP_WIDTH'(adet_reg);
        x2lo_next = CMP_WIDTH'(sx2_s4_reg.lo) * CMP_WIDTH'(adet_reg);
        x2hi_next = CMP_WIDTH'(sx2_s4_reg.hi) * CMP_WIDTH'(adet_reg);
        y2lo_next = CMP_WIDTH'(sy2_s4_reg.lo) * CMP_WIDTH'(adet_reg);
        y2hi_next = CMP_WIDTH'(sy2_s4_reg.hi) * CMP_WIDTH'(adet_reg);
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            snx_reg    <= snx_next;
            sny_reg    <= sny_next;
            x1lo_reg   <= x1lo_next;
            x1hi_reg   <= x1hi_next;
            y1lo_reg   <= y1lo_next;
            y1hi_reg   <= y1hi_next;
            x2lo_reg   <= x2lo_next;
            x2hi_reg   <= x2hi_next;
            y2lo_reg   <= y2lo_next;
            y2hi_reg   <= y2hi_next;
            par_s5_reg <= par_s4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: exact box checks, result register
    // ------------------------------------------------------------------
    seg_result_t res_next, res_reg;
    logic in_x1, in_y1, in_x2, in_y2;

    always_comb begin
        in_x1 = (x1lo_reg <= snx_reg) && (snx_reg <= x1hi_reg);
        in_y1 = (y1lo_reg <= sny_reg) && (sny_reg <= y1hi_reg);
        in_x2 = (x2lo_reg <= snx_reg) && (snx_reg <= x2hi_reg);
        in_y2 = (y2lo_reg <= sny_reg) && (sny_reg <= y2hi_reg);
        // parallel or collinear pairs never cross, overlap or not
        res_next.parallel = par_s5_reg;
        res_next.crosses  = !par_s5_reg && in_x1 && in_y1 && in_x2 && in_y2;
    end

    always_ff @(posedge aclk) begin
        if (en6) begin
            res_reg <= res_next;
        end
    end

    assign m_data = res_reg;

endmodule
